// ===== src/dpbc_pkg.sv =====
`timescale 1ns / 1ps

package dpbc_pkg;

	localparam int FIELD_W    = 32;
	localparam int N_IN       = 12;
	localparam int N_OUT      = 11;
	localparam int IN_DATA_W  = FIELD_W * N_IN;
	localparam int OUT_DATA_W = FIELD_W * N_OUT;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int GAIN_W     = 16;

	// shared multiplier: signed 48 x signed 17
	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 1;

	// serial divider: |acc| << 24 over omega^2
	localparam int DIV_W     = 56;
	localparam int DIV_CNT_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OMEGA = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MASS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DT    = 3'd5;

	localparam logic [GAIN_W-1:0] OMEGA_RST = 16'd4096;
	localparam logic [GAIN_W-1:0] DT_RST    = 16'd66;

	// 9.81 m/s^2 in Q16.16
	localparam logic signed [32:0] GRAV_Q16 = 33'sd642908;

	localparam logic signed [ACC_W-1:0] SAT_MAX = 66'sh0_7fff_ffff;
	localparam logic signed [ACC_W-1:0] SAT_MIN = -66'sh0_8000_0000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_KP,
		ST_KI,
		ST_PISUM,
		ST_PIW,
		ST_ACC,
		ST_LEAK,
		ST_DT,
		ST_INT,
		ST_FMUL,
		ST_FWR,
		ST_TMUL,
		ST_TACC,
		ST_TWR,
		ST_W2MUL,
		ST_W2WR,
		ST_DLOAD,
		ST_DSTEP,
		ST_DWR,
		ST_DONE
	} state_t;

	function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [FIELD_W-1:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7fff_ffff;
		end else if (v < SAT_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[FIELD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== src/dcm_pi_balance_controller_core.sv =====
`timescale 1ns / 1ps

// DCM PI balance controller, Q16.16 fixed point.
// s_tdata carries one control tick (12 x 32-bit fields); m_tdata carries the
// reference acceleration, zmp x/y, force and torque (11 x 32-bit fields).
// Both sides use tvalid/tready; a transaction happens when both are high.
// The cfg channel writes one register per transaction (cfg_ready is always
// high); any write to a known index also clears the leaky integral.
// After acceptance the sequencer runs the PI and integrator update per axis,
// then force, then the torque cross product, all through one shared 48x17
// multiplier, then the bit-serial divider for the zmp quotients (skipped when
// omega is zero). s_tready is high only while the sequencer is idle, so a new
// item is taken only once the sequencer is through with the last one.
// The result sits in an output register; the next item is accepted while it
// waits, and the sequencer holds at its last step if the previous result
// has still not been taken. Reset drops m_tvalid, clears the integral and
// loads register defaults (omega 1.0, time step 66).
module dcm_pi_balance_controller_core
	import dpbc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// dcm_x, dcm_y, dcm_z, dcm_des_x..z, com_des_x..z, acc_des_x..z
	input  logic [IN_DATA_W-1:0]   s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// acc_ref_x..z, zmp_ref_x, zmp_ref_y, force_x..z, torque_x..z
	output logic [OUT_DATA_W-1:0]  m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] kp_q, ki_q;
	logic [GAIN_W-1:0] decay_q, omega_q, mass_q, dt_q;

	logic signed [FIELD_W-1:0] integ_q [3];
	logic signed [FIELD_W-1:0] dcm_q [3];
	logic signed [FIELD_W-1:0] des_q [3];
	logic signed [FIELD_W-1:0] com_q [3];
	logic signed [FIELD_W-1:0] accd_q [3];
	logic signed [FIELD_W-1:0] acc_q [3];
	logic signed [FIELD_W-1:0] frc_q [3];
	logic signed [FIELD_W-1:0] trq_q [3];
	logic signed [FIELD_W-1:0] zmp_q [2];

	logic signed [ACC_W-1:0] accum_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [31:0] w2_q;
	logic [DIV_W-1:0] dvd_q;
	logic [31:0] rem_q;
	logic neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [1:0] ax_q, j_q;
	logic [OUT_DATA_W-1:0] out_q;
	logic m_valid_q;

	logic in_acc, cfg_acc, cfg_known, out_free;
	logic signed [32:0] err;
	logic signed [FIELD_W-1:0] integ_cur;
	logic [GAIN_W-1:0] kp_sel, ki_sel;
	logic signed [32:0] frc_v;
	logic [1:0] i1, i2;
	logic signed [FIELD_W-1:0] t_a, t_b;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [ACC_W-1:0] t_term, t_base;
	logic [31:0] mag;
	logic [32:0] trial;
	logic div_ge;
	logic signed [57:0] quo_s;

	assign in_acc    = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign cfg_known = (cfg_index == REG_KP) || (cfg_index == REG_KI) ||
		(cfg_index == REG_DECAY) || (cfg_index == REG_OMEGA) ||
		(cfg_index == REG_MASS) || (cfg_index == REG_DT);
	assign out_free  = !m_valid_q || m_tready;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = out_q;

	assign err       = 33'(des_q[ax_q]) - 33'(dcm_q[ax_q]);
	assign integ_cur = integ_q[ax_q];
	assign kp_sel    = kp_q[{ax_q, 4'b0000} +: GAIN_W];
	assign ki_sel    = ki_q[{ax_q, 4'b0000} +: GAIN_W];
	assign frc_v     = 33'(acc_q[ax_q]) + ((ax_q == 2'd2) ? GRAV_Q16 : 33'sd0);

	// cross product operand rotation
	always_comb begin
		case (ax_q)
			2'd0: begin
				i1 = 2'd1;
				i2 = 2'd2;
			end
			2'd1: begin
				i1 = 2'd2;
				i2 = 2'd0;
			end
			default: begin
				i1 = 2'd0;
				i2 = 2'd1;
			end
		endcase
	end

	// terms: a*b_lo, a*b_hi, c*d_lo, c*d_hi
	assign t_a = j_q[1] ? com_q[i2] : com_q[i1];
	assign t_b = j_q[1] ? frc_q[i1] : frc_q[i2];

	always_comb begin
		case (state_q)
			ST_KP: begin
				mul_a = MUL_A_W'(err);
				mul_b = $signed({1'b0, kp_sel});
			end
			ST_KI: begin
				mul_a = MUL_A_W'(integ_cur);
				mul_b = $signed({1'b0, ki_sel});
			end
			ST_PIW: begin
				mul_a = MUL_A_W'($signed(accum_q[49:8]));
				mul_b = $signed({1'b0, omega_q});
			end
			ST_ACC: begin
				mul_a = MUL_A_W'(integ_cur);
				mul_b = $signed({1'b0, decay_q});
			end
			ST_DT: begin
				mul_a = MUL_A_W'($signed(accum_q[40:0]));
				mul_b = $signed({1'b0, dt_q});
			end
			ST_FMUL: begin
				mul_a = MUL_A_W'(frc_v);
				mul_b = $signed({1'b0, mass_q});
			end
			ST_TMUL: begin
				mul_a = MUL_A_W'(t_a);
				mul_b = j_q[0] ? $signed({t_b[31], t_b[31:16]}) : $signed({1'b0, t_b[15:0]});
			end
			ST_W2MUL: begin
				mul_a = $signed({32'd0, omega_q});
				mul_b = $signed({1'b0, omega_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	assign t_term = j_q[0] ? (ACC_W'(prod_q) <<< 16) : ACC_W'(prod_q);
	assign t_base = (j_q == 2'd0) ? '0 : accum_q;

	assign mag    = acc_q[ax_q][31] ? (~acc_q[ax_q] + 32'd1) : acc_q[ax_q];
	assign trial  = {rem_q, dvd_q[DIV_W-1]};
	assign div_ge = trial >= {1'b0, w2_q};
	assign quo_s  = neg_q ? -$signed({2'b00, dvd_q}) : $signed({2'b00, dvd_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_KP;
			ST_KP:    state_d = ST_KI;
			ST_KI:    state_d = ST_PISUM;
			ST_PISUM: state_d = ST_PIW;
			ST_PIW:   state_d = ST_ACC;
			ST_ACC:   state_d = ST_LEAK;
			ST_LEAK:  state_d = ST_DT;
			ST_DT:    state_d = ST_INT;
			ST_INT:   state_d = (ax_q == 2'd2) ? ST_FMUL : ST_KP;
			ST_FMUL:  state_d = ST_FWR;
			ST_FWR:   state_d = (ax_q == 2'd2) ? ST_TMUL : ST_FMUL;
			ST_TMUL:  state_d = ST_TACC;
			ST_TACC:  state_d = (j_q == 2'd3) ? ST_TWR : ST_TMUL;
			ST_TWR:   state_d = (ax_q == 2'd2) ? ST_W2MUL : ST_TMUL;
			ST_W2MUL: state_d = ST_W2WR;
			ST_W2WR:  state_d = ST_DLOAD;
			ST_DLOAD: begin
				if (omega_q != '0) begin
					state_d = ST_DSTEP;
				end else if (ax_q == 2'd1) begin
					state_d = ST_DONE;
				end
			end
			ST_DSTEP: if (cnt_q == DIV_CNT_W'(DIV_W - 1)) state_d = ST_DWR;
			ST_DWR:   state_d = (ax_q == 2'd1) ? ST_DONE : ST_DLOAD;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ax_q      <= '0;
			j_q       <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
			kp_q      <= '0;
			ki_q      <= '0;
			decay_q   <= '0;
			omega_q   <= OMEGA_RST;
			mass_q    <= '0;
			dt_q      <= DT_RST;
			for (int k = 0; k < 3; k++) integ_q[k] <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_acc && cfg_known) begin
				case (cfg_index)
					REG_KP:    kp_q <= cfg_data;
					REG_KI:    ki_q <= cfg_data;
					REG_DECAY: decay_q <= cfg_data[GAIN_W-1:0];
					REG_OMEGA: omega_q <= cfg_data[GAIN_W-1:0];
					REG_MASS:  mass_q <= cfg_data[GAIN_W-1:0];
					REG_DT:    dt_q <= cfg_data[GAIN_W-1:0];
					default:   ;
				endcase
				for (int k = 0; k < 3; k++) integ_q[k] <= '0;
			end

			case (state_q)
				ST_IDLE: begin
					ax_q <= '0;
					j_q  <= '0;
				end
				ST_INT: begin
					integ_q[ax_q] <= sat32(ACC_W'(integ_cur) + ACC_W'(prod_q >>> 16));
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				end
				ST_FWR:   ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				ST_TACC:  j_q <= j_q + 2'd1;
				ST_TWR:   ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				ST_DLOAD: begin
					cnt_q <= '0;
					if (omega_q == '0) ax_q <= (ax_q == 2'd1) ? 2'd0 : ax_q + 2'd1;
				end
				ST_DSTEP: cnt_q <= cnt_q + DIV_CNT_W'(1);
				ST_DWR:   ax_q <= (ax_q == 2'd1) ? 2'd0 : ax_q + 2'd1;
				default:  ;
			endcase

			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					for (int k = 0; k < 3; k++) begin
						dcm_q[k]  <= s_tdata[FIELD_W*k +: FIELD_W];
						des_q[k]  <= s_tdata[FIELD_W*(3+k) +: FIELD_W];
						com_q[k]  <= s_tdata[FIELD_W*(6+k) +: FIELD_W];
						accd_q[k] <= s_tdata[FIELD_W*(9+k) +: FIELD_W];
					end
				end
			end
			ST_KI:    accum_q <= ACC_W'(prod_q);
			ST_PISUM: accum_q <= accum_q + ACC_W'(prod_q);
			ST_ACC:   acc_q[ax_q] <= sat32(ACC_W'(accd_q[ax_q]) + ACC_W'(prod_q >>> 12));
			ST_LEAK:  accum_q <= ACC_W'(err) - ACC_W'(prod_q >>> 8);
			ST_FWR:   frc_q[ax_q] <= sat32(ACC_W'(prod_q >>> 8));
			ST_TACC:  accum_q <= j_q[1] ? (t_base - t_term) : (t_base + t_term);
			ST_TWR:   trq_q[ax_q] <= sat32(accum_q >>> 16);
			ST_W2WR:  w2_q <= prod_q[31:0];
			ST_DLOAD: begin
				if (omega_q == '0) zmp_q[ax_q[0]] <= com_q[ax_q];
				neg_q <= acc_q[ax_q][31];
				dvd_q <= {mag, 24'd0};
				rem_q <= '0;
			end
			ST_DSTEP: begin
				rem_q <= div_ge ? 32'(trial - {1'b0, w2_q}) : trial[31:0];
				dvd_q <= {dvd_q[DIV_W-2:0], div_ge};
			end
			ST_DWR:   zmp_q[ax_q[0]] <= sat32(ACC_W'(com_q[ax_q]) - ACC_W'(quo_s));
			ST_DONE: begin
				if (out_free) begin
					out_q <= {trq_q[2], trq_q[1], trq_q[0], frc_q[2], frc_q[1], frc_q[0],
						zmp_q[1], zmp_q[0], acc_q[2], acc_q[1], acc_q[0]};
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== src/dpbc_checker.sv =====
`timescale 1ns / 1ps

module dpbc_checker
	import dpbc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// result held while the sink stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed under stall");

	// block goes busy after taking an item
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready after a transaction");

	// a result cannot show up right after an item is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// reset clears any pending result
	assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("m_tvalid high after reset");

endmodule

bind dcm_pi_balance_controller_core dpbc_checker u_dpbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import dpbc_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// dcm_x, dcm_y, dcm_z, dcm_des_x..z, com_des_x..z, acc_des_x..z
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// acc_ref_x..z, zmp_ref_x, zmp_ref_y, force_x..z, torque_x..z
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	dcm_pi_balance_controller_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// controller copy: registers and leaky integral
	logic [47:0] kp_q, ki_q;
	logic [15:0] decay_q, omega_q, mass_q, dt_q;
	longint      integ_q[3];

	logic [OUT_DATA_W-1:0] pending_results[$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_len = 0;

	typedef struct {
		logic [IN_DATA_W-1:0]  din;
		bit                    chk;
		logic [OUT_DATA_W-1:0] dout;
	} tick_row_t;

	tick_row_t rows[$];

	function automatic longint clamp32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 64'sd2147483647;
		if (v < -128'sd2147483648) return -64'sd2147483648;
		return longint'(v);
	endfunction

	// floor((a*b - c*d) / 2^16), exact
	function automatic longint cross_q16(input longint a, b, c, d);
		logic signed [127:0] p1, p2;
		p1 = 128'(a);
		p1 = p1 * 128'(b);
		p2 = 128'(c);
		p2 = p2 * 128'(d);
		return clamp32((p1 - p2) >>> 16);
	endfunction

	function automatic logic [OUT_DATA_W-1:0] balance_step(input logic [IN_DATA_W-1:0] d);
		longint acc[3], com[3], frc[3], zmp[2];
		longint meas, des, accd, err, kp, ki, integ, pi, a, leak, delta;
		longint om, dec, dt, ms, w2, q;
		logic [OUT_DATA_W-1:0] r;
		om = longint'(omega_q);
		dec = longint'(decay_q);
		dt = longint'(dt_q);
		ms = longint'(mass_q);
		for (int k = 0; k < 3; k++) begin
			meas = longint'($signed(d[32*k +: 32]));
			des = longint'($signed(d[32*(3+k) +: 32]));
			com[k] = longint'($signed(d[32*(6+k) +: 32]));
			accd = longint'($signed(d[32*(9+k) +: 32]));
			kp = longint'(kp_q[16*k +: 16]);
			ki = longint'(ki_q[16*k +: 16]);
			err = des - meas;
			integ = integ_q[k];
			pi = (kp * err + ki * integ) >>> 8;
			a = accd + ((pi * om) >>> 12);
			leak = (dec * integ) >>> 8;
			delta = ((err - leak) * dt) >>> 16;
			acc[k] = clamp32(a);
			integ_q[k] = clamp32(integ + delta);
		end
		for (int k = 0; k < 2; k++) begin
			if (om == 0) begin
				zmp[k] = com[k];
			end else begin
				w2 = om * om;
				q = (acc[k] * 64'sd16777216) / w2;
				zmp[k] = clamp32(com[k] - q);
			end
		end
		frc[0] = clamp32((ms * acc[0]) >>> 8);
		frc[1] = clamp32((ms * acc[1]) >>> 8);
		frc[2] = clamp32((ms * (acc[2] + longint'(GRAV_Q16))) >>> 8);
		r[0 +: 32] = 32'(acc[0]);
		r[32 +: 32] = 32'(acc[1]);
		r[64 +: 32] = 32'(acc[2]);
		r[96 +: 32] = 32'(zmp[0]);
		r[128 +: 32] = 32'(zmp[1]);
		r[160 +: 32] = 32'(frc[0]);
		r[192 +: 32] = 32'(frc[1]);
		r[224 +: 32] = 32'(frc[2]);
		r[256 +: 32] = 32'(cross_q16(com[1], frc[2], com[2], frc[1]));
		r[288 +: 32] = 32'(cross_q16(com[2], frc[0], com[0], frc[2]));
		r[320 +: 32] = 32'(cross_q16(com[0], frc[1], com[1], frc[0]));
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_KP:    kp_q = val;
			REG_KI:    ki_q = val;
			REG_DECAY: decay_q = val[15:0];
			REG_OMEGA: omega_q = val[15:0];
			REG_MASS:  mass_q = val[15:0];
			REG_DT:    dt_q = val[15:0];
			default:   ;
		endcase
		if (idx <= REG_DT)
			for (int k = 0; k < 3; k++) integ_q[k] = 0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [47:0] kp, ki, input logic [15:0] dec, om, ms, dt);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_DECAY, 48'(dec));
		write_reg(REG_OMEGA, 48'(om));
		write_reg(REG_MASS, 48'(ms));
		write_reg(REG_DT, 48'(dt));
	endtask

	task automatic send_tick(input logic [IN_DATA_W-1:0] d, input bit chk,
			input logic [OUT_DATA_W-1:0] dout);
		logic [OUT_DATA_W-1:0] res;
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		res = balance_step(d);
		pending_results.push_back(chk ? dout : res);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_field();
		case ($urandom_range(9))
			0, 1, 2: return $urandom;
			3:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
		endcase
	endfunction

	function automatic logic [IN_DATA_W-1:0] rand_tick();
		logic [IN_DATA_W-1:0] d;
		for (int k = 0; k < N_IN; k++) d[32*k +: 32] = rand_field();
		return d;
	endfunction

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_len > 0) begin
			hold_len = hold_len - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		logic [OUT_DATA_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = pending_results.pop_front();
				for (int k = 0; k < N_OUT; k++)
					if (m_tdata[32*k +: 32] !== want[32*k +: 32])
						report_mismatch($sformatf("field %0d got %h want %h",
							k, m_tdata[32*k +: 32], want[32*k +: 32]));
			end
		end
	end

	initial begin
		#60ms;
		$display("[dcm_pi_balance_controller_core] ERROR");
		$finish;
	end

	initial begin
		tick_row_t row;
		int n_dir;
		kp_q = '0;
		ki_q = '0;
		decay_q = '0;
		omega_q = OMEGA_RST;
		mass_q = '0;
		dt_q = DT_RST;
		for (int k = 0; k < 3; k++) integ_q[k] = 0;

		// after reset everything is zero
		row.din = '0;
		row.chk = 1;
		row.dout = '0;
		rows.push_back(row);
		// saturated desired acceleration passes straight through, zmp = -acc
		row.din = '0;
		row.din[32*9 +: 32] = 32'h7fffffff;
		row.dout = '0;
		row.dout[0 +: 32] = 32'h7fffffff;
		row.dout[96 +: 32] = 32'h80000001;
		rows.push_back(row);
		row.chk = 0;
		row.din = {N_IN{32'h7fffffff}};
		rows.push_back(row);
		row.din = {N_IN{32'h80000000}};
		rows.push_back(row);
		row.din = {{9{32'h80000000}}, {3{32'h7fffffff}}};
		rows.push_back(row);
		row.din = {{9{32'h7fffffff}}, {3{32'h80000000}}};
		rows.push_back(row);
		row.din = {N_IN{32'hffffffff}};
		rows.push_back(row);
		row.din = {(N_IN/2){32'haaaaaaaa, 32'h55555555}};
		rows.push_back(row);
		n_dir = rows.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (rows[i]) send_tick(rows[i].din, rows[i].chk, rows[i].dout);
		wait_drained();

		// all registers at their maximum
		write_all('1, '1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		for (int i = 2; i < n_dir; i++) send_tick(rows[i].din, 0, '0);
		for (int i = 0; i < 3; i++) send_tick(rand_tick(), 0, '0);
		wait_drained();

		// zero omega skips the zmp division
		write_all(48'h0100_0080_0040, 48'h0020_0010_0008, 16'h0010, 16'h0000,
			16'h4000, 16'h0001);
		for (int i = 2; i < 6; i++) send_tick(rows[i].din, 0, '0);
		wait_drained();

		// unknown indexes must leave the integral alone
		write_reg(REG_OMEGA, 48'h1000);
		for (int i = 0; i < 3; i++) send_tick(rand_tick(), 0, '0);
		wait_drained();
		write_reg(3'd6, '1);
		write_reg(3'd7, 48'h1234_5678_9abc);
		for (int i = 0; i < 3; i++) send_tick(rand_tick(), 0, '0);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 46; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 46; end
				default: begin send_idle = 26; recv_idle = 26; end
			endcase
			if (ph == 5)
				write_all('0, '0, 16'h0000, 16'h0001, 16'h0000, 16'h0001);
			else
				write_all(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
					16'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom),
					16'($urandom_range(1, 65535)));
			for (int i = 0; i < 250; i++) begin
				// the sink backs up while ticks keep coming
				if (ph == 2 && i == 100) hold_len = 2000;
				send_tick(rand_tick(), 0, '0);
			end
			wait_drained();
		end

		send_idle = 0;
		recv_idle = 0;
		if (errors == 0) begin
			$display("[dcm_pi_balance_controller_core] OK");
		end else begin
			$display("[dcm_pi_balance_controller_core] ERROR");
		end
		$finish;
	end

endmodule
